// ===== rtl/gtl_pkg.sv =====
// Shared types and constants of the glyph text layout block.
package gtl_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] CFG_BOX_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_BOX_HEIGHT   = 3'd3;
    localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd4;
    localparam logic [2:0] CFG_MODE         = 3'd5;

    // Input opcodes, modes and result kinds.
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CHAR     = 1'b1;
    localparam logic MODE_LAYOUT  = 1'b0;
    localparam logic MODE_MEASURE = 1'b1;
    localparam logic KIND_BLIT   = 1'b0;
    localparam logic KIND_WIDTH  = 1'b1;

    // Character codes and spacing.
    localparam logic [7:0] CODE_SPACE    = 8'd32;
    localparam logic [7:0] CODE_NEWLINE  = 8'd10;
    localparam logic [7:0] SPACE_ADVANCE = 8'd3;
    localparam logic [7:0] XSPACE        = 8'd1;
    localparam logic [7:0] YSPACE        = 8'd3;

    // Table entry as stored in the glyph memory.
    localparam int ENTRY_W = 28;

    typedef struct packed {
        logic [7:0]  width;
        logic [11:0] start;
        logic [7:0]  code;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRAP,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic wrap;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic is_load;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== rtl/glyph_text_layout.sv =====
// A load goes through the scan, drain and commit states before the next item can be
// accepted, and a character through scan, drain, wrap and commit; a result appears in
// the output register the cycle after its item finishes. One item is in work at a time,
// commit waits on a stalled output, and the scan reads one glyph memory entry per cycle.
// Reset (asynchronous, active low) restores the configuration defaults, marks every
// table slot empty and clears the cursor, width sum and halt flag at once.
module glyph_text_layout
    import gtl_pkg::*;
#(
    parameter int NUM_GLYPHS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[6:0], entry_code[14:7], entry_start[26:15], entry_width[34:27],
    // char_code[42:35], zero fill
    input  logic [47:0] s_tdata,
    // opcode
    input  logic        s_tuser,
    // end_of_text
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // atlas_x[11:0], blit_width[19:12], dest_x[36:20], dest_y[53:37],
    // text_total[69:54], zero fill
    output logic [71:0] m_tdata,
    // result_kind
    output logic        m_tuser
);

    dp_cmd_t    cmd;
    dp_status_t status;

    gtl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gtl_datapath #(
        .NUM_GLYPHS (NUM_GLYPHS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .in_last   (s_tlast),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== rtl/gtl_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module gtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gtl_ctrl.sv =====
// Controller state machine that sequences table scans and result commits.
module gtl_ctrl
    import gtl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last read of the scan is compared in this cycle.
                state_next = status.is_load ? ST_COMMIT : ST_WRAP;
            end
            ST_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/gtl_datapath.sv =====
// Datapath: glyph table, lookup scan, cursor state and the output register.
module gtl_datapath
    import gtl_pkg::*;
#(
    parameter int NUM_GLYPHS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [47:0] in_data,
    input  logic        in_user,
    input  logic        in_last,
    output logic [71:0] out_data,
    output logic        out_user,
    output logic        out_valid,
    input  logic        out_ready,
    input  dp_cmd_t     cmd,
    output dp_status_t  status
);

    localparam int IDX_W = NUM_GLYPHS > 1 ? $clog2(NUM_GLYPHS) : 1;

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    // Configuration registers.
    logic [15:0] origin_x_reg;
    logic [15:0] origin_y_reg;
    logic [14:0] box_width_reg;
    logic [14:0] box_height_reg;
    logic [7:0]  glyph_height_reg;
    logic        mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            box_width_reg    <= 15'h7FFF;
            box_height_reg   <= 15'h7FFF;
            glyph_height_reg <= 8'd16;
            mode_reg         <= MODE_LAYOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                CFG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                CFG_BOX_WIDTH:    box_width_reg    <= cfg_data[14:0];
                CFG_BOX_HEIGHT:   box_height_reg   <= cfg_data[14:0];
                CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[7:0];
                CFG_MODE:         mode_reg         <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Current item.
    logic        opcode_reg;
    logic [6:0]  slot_reg;
    logic [7:0]  ecode_reg;
    logic [11:0] estart_reg;
    logic [7:0]  ewidth_reg;
    logic [7:0]  ch_reg;
    logic        eot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            opcode_reg <= in_user;
            slot_reg   <= in_data[6:0];
            ecode_reg  <= in_data[14:7];
            estart_reg <= in_data[26:15];
            ewidth_reg <= in_data[34:27];
            ch_reg     <= in_data[42:35];
            eot_reg    <= in_last;
        end
    end

    // Table memory and per-slot valid bits.
    logic [NUM_GLYPHS-1:0] valid_reg;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_pending_reg;
    logic [ENTRY_W-1:0]    rdata;
    entry_t                rd_entry;
    entry_t                wr_entry;
    logic                  slot_in_range;
    logic                  table_we;
    logic [IDX_W-1:0]      slot_idx;

    logic                  match_found_reg;
    logic [11:0]           match_start_reg;
    logic [7:0]            match_width_reg;
    logic                  best_found_reg;
    logic [7:0]            best_code_reg;
    logic [11:0]           best_start_reg;
    logic [7:0]            best_width_reg;

    assign slot_in_range = {2'b00, slot_reg} < 9'(NUM_GLYPHS);
    assign slot_idx      = IDX_W'(slot_reg);
    assign wr_entry      = '{width: ewidth_reg, start: estart_reg, code: ecode_reg};
    // A load whose code is already present is dropped; the scan found it as a match.
    assign table_we      = cmd.commit && (opcode_reg == OP_LOAD) && slot_in_range
                           && !match_found_reg;
    assign rd_entry      = entry_t'(rdata);

    gtl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_GLYPHS)
    ) u_table (
        .clk   (clk),
        .we    (table_we),
        .waddr (slot_idx),
        .wdata (wr_entry),
        .re    (cmd.scan),
        .raddr (scan_idx_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            rd_pending_reg <= cmd.scan;
            if (table_we)
            begin
                valid_reg[slot_idx] <= 1'b1;
            end
        end
    end

    // Scan: one entry read per cycle, each compared in the cycle after its read.
    logic [7:0] key;
    assign key = (opcode_reg == OP_LOAD) ? ecode_reg : ch_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            scan_idx_reg    <= '0;
            match_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                rd_idx_reg   <= scan_idx_reg;
            end
            if (rd_pending_reg && valid_reg[rd_idx_reg])
            begin
                if (!match_found_reg && rd_entry.code == key)
                begin
                    match_found_reg <= 1'b1;
                    match_start_reg <= rd_entry.start;
                    match_width_reg <= rd_entry.width;
                end
                if (!best_found_reg || rd_entry.code < best_code_reg)
                begin
                    best_found_reg <= 1'b1;
                    best_code_reg  <= rd_entry.code;
                    best_start_reg <= rd_entry.start;
                    best_width_reg <= rd_entry.width;
                end
            end
        end
    end

    logic        found;
    logic [7:0]  sel_width;
    logic [11:0] sel_start;

    assign found     = match_found_reg || best_found_reg;
    assign sel_width = match_found_reg ? match_width_reg : best_width_reg;
    assign sel_start = match_found_reg ? match_start_reg : best_start_reg;

    // Cursor state and output register.
    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic [15:0] width_sum_reg, width_sum_next;
    logic        halted_reg, halted_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [71:0] out_data_reg, out_data_next;

    logic [8:0]  line_step;
    logic [15:0] cy_stepped;
    logic        is_glyph;
    logic        wrap_needed;
    logic        over_height;
    logic [16:0] dest_x;
    logic [16:0] dest_y;
    logic [7:0]  measure_add;
    logic [15:0] sum_new;

    assign line_step   = {1'b0, glyph_height_reg} + {1'b0, YSPACE};
    assign cy_stepped  = sat16({1'b0, cursor_y_reg} + {8'b0, line_step});
    assign is_glyph    = (ch_reg != CODE_SPACE) && (ch_reg != CODE_NEWLINE);
    assign wrap_needed = ({1'b0, cursor_x_reg} + {9'b0, sel_width}) > {2'b00, box_width_reg};
    assign over_height = {2'b00, box_height_reg}
                         < ({9'b0, glyph_height_reg} + {1'b0, cursor_y_reg});
    assign dest_x      = {origin_x_reg[15], origin_x_reg} + {1'b0, cursor_x_reg};
    assign dest_y      = {origin_y_reg[15], origin_y_reg} + {1'b0, cursor_y_reg};
    assign measure_add = (ch_reg == CODE_SPACE) ? SPACE_ADVANCE : (found ? sel_width : 8'd0);
    assign sum_new     = sat16({1'b0, width_sum_reg} + {9'b0, measure_add});

    always_comb
    begin
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        width_sum_next = width_sum_reg;
        halted_next    = halted_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;

        // Wrap is applied first so the height check sees the new line.
        if (cmd.wrap && mode_reg == MODE_LAYOUT && !halted_reg && is_glyph
            && found && wrap_needed)
        begin
            cursor_x_next = '0;
            cursor_y_next = cy_stepped;
        end

        if (cmd.commit && opcode_reg == OP_CHAR)
        begin
            if (mode_reg == MODE_MEASURE)
            begin
                width_sum_next = sum_new;
                if (eot_reg)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_WIDTH;
                    out_data_next  = {2'b00, sum_new, 54'b0};
                end
            end
            else if (!halted_reg)
            begin
                if (ch_reg == CODE_SPACE)
                begin
                    cursor_x_next = sat16({1'b0, cursor_x_reg} + {9'b0, SPACE_ADVANCE});
                end
                else if (ch_reg == CODE_NEWLINE)
                begin
                    cursor_x_next = '0;
                    cursor_y_next = cy_stepped;
                end
                else if (found)
                begin
                    if (over_height)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_BLIT;
                        out_data_next  = {18'b0, dest_y, dest_x, sel_width, sel_start};
                        cursor_x_next  = sat16({1'b0, cursor_x_reg} + {9'b0, sel_width}
                                               + {9'b0, XSPACE});
                    end
                end
            end
            if (eot_reg)
            begin
                cursor_x_next  = '0;
                cursor_y_next  = '0;
                width_sum_next = '0;
                halted_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            width_sum_reg <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            width_sum_reg <= width_sum_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_user         = out_kind_reg;
    assign out_data         = out_data_reg;
    assign status.scan_last = scan_idx_reg == IDX_W'(NUM_GLYPHS - 1);
    assign status.is_load   = opcode_reg == OP_LOAD;
    assign status.out_busy  = out_valid_reg && !out_ready;

endmodule

// ===== verif/tb_glyph_text_layout.sv =====
// Self-checking testbench for the glyph text layout block.
`timescale 1ns / 100ps

module tb_glyph_text_layout;
    import gtl_pkg::*;

    localparam int GLYPH_SLOTS   = 128;
    localparam int SETTLE_CYCLES = GLYPH_SLOTS + 24;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int ITEM_TARGET   = 850;

    // One blit or measured width, as the block returns it.
    typedef struct packed {
        logic        kind;
        logic [11:0] atlas_x;
        logic [7:0]  blit_width;
        logic [16:0] dest_x;
        logic [16:0] dest_y;
        logic [15:0] text_total;
    } draw_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tuser;

    // Glyph table and text state as the block should hold them.
    logic [7:0]  tbl_code  [GLYPH_SLOTS];
    logic [11:0] tbl_start [GLYPH_SLOTS];
    logic [7:0]  tbl_width [GLYPH_SLOTS];
    bit          tbl_valid [GLYPH_SLOTS];
    int          cursor_x = 0;
    int          cursor_y = 0;
    int          width_sum = 0;
    bit          halted = 1'b0;

    int          org_x = 0;
    int          org_y = 0;
    int          box_w = 32767;
    int          box_h = 32767;
    int          glyph_h = 16;
    logic        text_mode = MODE_LAYOUT;

    draw_t       draws_due [$];
    int          err_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          rx_left = 0;
    int          rx_kind = 0;

    glyph_text_layout #(
        .NUM_GLYPHS(GLYPH_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        err_count++;
        if (err_count <= 30)
            $display("MISMATCH at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic int clip16(int v);
        return (v > 65535) ? 65535 : v;
    endfunction

    // Exact code match first; otherwise the smallest loaded code, lowest slot on ties.
    function automatic int find_slot(logic [7:0] c);
        int i;
        int best;
        best = -1;
        for (i = 0; i < GLYPH_SLOTS; i++)
        begin
            if (tbl_valid[i])
            begin
                if (tbl_code[i] == c)
                    return i;
                if (best < 0 || tbl_code[i] < tbl_code[best])
                    best = i;
            end
        end
        return best;
    endfunction

    task automatic typeset_item(logic op, logic [6:0] slot, logic [7:0] code,
                                logic [11:0] start, logic [7:0] width, logic [7:0] ch,
                                logic eot);
        int    i;
        int    g;
        int    w;
        int    line_step;
        int    dx;
        int    dy;
        bit    dup;
        draw_t d;
        if (op == OP_LOAD)
        begin
            dup = 1'b0;
            for (i = 0; i < GLYPH_SLOTS; i++)
                if (tbl_valid[i] && tbl_code[i] == code)
                    dup = 1'b1;
            if (!dup)
            begin
                tbl_code[slot]  = code;
                tbl_start[slot] = start;
                tbl_width[slot] = width;
                tbl_valid[slot] = 1'b1;
            end
            return;
        end
        d = '0;
        if (text_mode == MODE_MEASURE)
        begin
            if (ch == CODE_SPACE)
                width_sum = clip16(width_sum + SPACE_ADVANCE);
            else
            begin
                g = find_slot(ch);
                if (g >= 0)
                    width_sum = clip16(width_sum + tbl_width[g]);
            end
            if (eot)
            begin
                d.kind = KIND_WIDTH;
                d.text_total = width_sum[15:0];
                draws_due.push_back(d);
            end
        end
        else if (!halted)
        begin
            line_step = glyph_h + YSPACE;
            if (ch == CODE_SPACE)
                cursor_x = clip16(cursor_x + SPACE_ADVANCE);
            else if (ch == CODE_NEWLINE)
            begin
                cursor_y = clip16(cursor_y + line_step);
                cursor_x = 0;
            end
            else
            begin
                g = find_slot(ch);
                if (g >= 0)
                begin
                    w = tbl_width[g];
                    if (cursor_x + w > box_w)
                    begin
                        cursor_x = 0;
                        cursor_y = clip16(cursor_y + line_step);
                    end
                    if (box_h < glyph_h + cursor_y)
                        halted = 1'b1;
                    else
                    begin
                        dx = org_x + cursor_x;
                        dy = org_y + cursor_y;
                        d.kind = KIND_BLIT;
                        d.atlas_x = tbl_start[g];
                        d.blit_width = tbl_width[g];
                        d.dest_x = dx[16:0];
                        d.dest_y = dy[16:0];
                        draws_due.push_back(d);
                        cursor_x = clip16(cursor_x + w + XSPACE);
                    end
                end
            end
        end
        if (eot)
        begin
            cursor_x = 0;
            cursor_y = 0;
            halted = 1'b0;
            width_sum = 0;
        end
    endtask

    // The sender works in bursts; a gap before a burst is counted in clock cycles.
    task automatic send_item(logic op, logic [6:0] slot, logic [7:0] code, logic [11:0] start,
                             logic [7:0] width, logic [7:0] ch, logic eot);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 4);
                2: gap = $urandom_range(5, 40);
                default: gap = $urandom_range(41, 170);
            endcase
        end
        burst_left--;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= eot;
        s_tdata  <= {5'b0, ch, width, start, code, slot};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        typeset_item(op, slot, code, start, width, ch, eot);
        items_sent++;
    endtask

    task automatic send_load(logic [6:0] slot, logic [7:0] code, logic [11:0] start,
                             logic [7:0] width);
        send_item(OP_LOAD, slot, code, start, width, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_char(logic [7:0] ch, logic eot);
        send_item(OP_CHAR, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                  12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)), ch, eot);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:     org_x = int'($signed(val));
            CFG_ORIGIN_Y:     org_y = int'($signed(val));
            CFG_BOX_WIDTH:    box_w = int'(val[14:0]);
            CFG_BOX_HEIGHT:   box_h = int'(val[14:0]);
            CFG_GLYPH_HEIGHT: glyph_h = int'(val[7:0]);
            CFG_MODE:         text_mode = val[0];
            default: ;
        endcase
    endtask

    // Holds the sender back until every pending result is out and the block is idle.
    task automatic wait_idle();
        int n;
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        n = 0;
        while (draws_due.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_loaded_code();
        int base;
        int i;
        base = $urandom_range(0, GLYPH_SLOTS - 1);
        for (i = 0; i < GLYPH_SLOTS; i++)
            if (tbl_valid[(base + i) % GLYPH_SLOTS])
                return tbl_code[(base + i) % GLYPH_SLOTS];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return pick_loaded_code();
        if (r == 6)
            return CODE_SPACE;
        if (r == 7)
            return CODE_NEWLINE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_empty_table();
        send_char(8'd65, 1'b0);
        send_char(CODE_SPACE, 1'b0);
        send_char(CODE_NEWLINE, 1'b0);
        send_char(8'd66, 1'b1);
        wait_idle();
        set_reg(CFG_MODE, 16'(MODE_MEASURE));
        // Only the space counts while the table is empty.
        send_char(CODE_SPACE, 1'b0);
        send_char(8'd120, 1'b1);
    endtask

    task automatic test_table_loads();
        wait_idle();
        set_reg(CFG_MODE, 16'(MODE_LAYOUT));
        send_load(7'd0, 8'd65, 12'd0, 8'd0);
        send_load(7'd127, 8'd255, 12'hFFF, 8'd255);
        send_load(7'd5, 8'd0, 12'h555, 8'd7);
        // Both reloads of an existing code must leave the first entry in place.
        send_load(7'd9, 8'd65, 12'd100, 8'd9);
        send_load(7'd0, 8'd65, 12'd200, 8'd3);
        send_load(7'd10, 8'd66, 12'hAAA, 8'hAA);
        send_load(7'd11, CODE_NEWLINE, 12'd40, 8'd5);
        send_load(7'd12, 8'd85, 12'd0, 8'd85);
    endtask

    task automatic test_layout_cases();
        wait_idle();
        set_reg(CFG_ORIGIN_X, 16'h8000);
        set_reg(CFG_ORIGIN_Y, 16'h7FFF);
        set_reg(CFG_BOX_WIDTH, 16'd20);
        set_reg(CFG_BOX_HEIGHT, 16'd60);
        set_reg(CFG_GLYPH_HEIGHT, 16'd16);
        send_char(8'd65, 1'b0);
        send_char(8'd200, 1'b0);
        send_char(8'd200, 1'b0);
        send_char(8'd200, 1'b0);
        send_char(CODE_SPACE, 1'b0);
        send_char(CODE_NEWLINE, 1'b0);
        // A wide glyph wraps past the box height and halts the text.
        send_char(8'd66, 1'b0);
        send_char(8'd65, 1'b0);
        send_char(8'd65, 1'b1);
        send_char(8'd85, 1'b1);
    endtask

    task automatic test_measure_cases();
        wait_idle();
        set_reg(CFG_MODE, 16'(MODE_MEASURE));
        send_char(8'd66, 1'b0);
        send_char(CODE_SPACE, 1'b0);
        // In measure mode a newline is just another glyph.
        send_char(CODE_NEWLINE, 1'b0);
        send_char(8'd255, 1'b0);
        send_char(8'd7, 1'b1);
    endtask

    task automatic test_saturation();
        logic [7:0] fresh;
        bit         hit;
        int         i;
        wait_idle();
        set_reg(CFG_MODE, 16'(MODE_MEASURE));
        do
        begin
            fresh = 8'($urandom_range(0, 255));
            hit = 1'b0;
            for (i = 0; i < GLYPH_SLOTS; i++)
                if (tbl_valid[i] && tbl_code[i] == fresh)
                    hit = 1'b1;
        end
        while (hit);
        send_load(7'($urandom_range(0, 127)), fresh, 12'($urandom_range(0, 4095)), 8'd255);
        for (i = 0; i < 280; i++)
            send_char(($urandom_range(0, 31) == 0) ? CODE_SPACE : fresh, i == 279);
        send_char(fresh, 1'b0);
        send_char(CODE_SPACE, 1'b1);

        // Enough newlines to pin the line position at its ceiling.
        wait_idle();
        set_reg(CFG_MODE, 16'(MODE_LAYOUT));
        set_reg(CFG_ORIGIN_X, 16'd0);
        set_reg(CFG_ORIGIN_Y, 16'd0);
        set_reg(CFG_BOX_WIDTH, 16'd32767);
        set_reg(CFG_BOX_HEIGHT, 16'd32767);
        set_reg(CFG_GLYPH_HEIGHT, 16'd255);
        send_char(fresh, 1'b0);
        for (i = 0; i < 256; i++)
            send_char(CODE_NEWLINE, 1'b0);
        send_char(fresh, 1'b0);
        send_char(fresh, 1'b1);
        send_char(fresh, 1'b1);
    endtask

    task automatic test_random_texts();
        int  len;
        int  i;
        int  r;
        bit  broken;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            r = $urandom_range(0, 3);
            set_reg(CFG_ORIGIN_X, (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF
                                           : 16'($urandom_range(0, 65535)));
            r = $urandom_range(0, 3);
            set_reg(CFG_ORIGIN_Y, (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF
                                           : 16'($urandom_range(0, 65535)));
            r = $urandom_range(0, 7);
            set_reg(CFG_BOX_WIDTH, (r == 0) ? 16'd0 : (r == 1) ? 16'd32767
                                            : 16'($urandom_range(0, 600)));
            r = $urandom_range(0, 9);
            set_reg(CFG_BOX_HEIGHT, (r == 0) ? 16'd0 : (r < 3) ? 16'd32767
                                             : 16'($urandom_range(0, 300)));
            r = $urandom_range(0, 7);
            set_reg(CFG_GLYPH_HEIGHT, (r == 0) ? 16'd1 : (r == 1) ? 16'd255
                                               : 16'($urandom_range(1, 24)));
            set_reg(CFG_MODE, ($urandom_range(0, 3) == 0) ? 16'(MODE_MEASURE)
                                                          : 16'(MODE_LAYOUT));

            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 6))
                    send_load(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                              12'($urandom_range(0, 4095)),
                              ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 30)));
            len = $urandom_range(1, 24);
            broken = ($urandom_range(0, 7) == 0);
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_load(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                              12'($urandom_range(0, 4095)), 8'($urandom_range(0, 30)));
                send_char(pick_text_byte(), (i == len - 1) && !broken);
            end
        end
    endtask

    // Result receiver: long ready stretches, hard stalls and per-cycle jitter.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_kind = $urandom_range(0, 2);
            rx_left = (rx_kind == 1) ? $urandom_range(1, 60) : $urandom_range(20, 400);
        end
        rx_left--;
        case (rx_kind)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'b0;
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge clk)
    begin : check_draws
        draw_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (draws_due.size() == 0)
                report_mismatch("result with nothing pending", m_tdata[63:0], 0);
            else
            begin
                want = draws_due.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("result_kind", m_tuser, want.kind);
                if (m_tdata[11:0] !== want.atlas_x)
                    report_mismatch("atlas_x", m_tdata[11:0], want.atlas_x);
                if (m_tdata[19:12] !== want.blit_width)
                    report_mismatch("blit_width", m_tdata[19:12], want.blit_width);
                if (m_tdata[36:20] !== want.dest_x)
                    report_mismatch("dest_x", m_tdata[36:20], want.dest_x);
                if (m_tdata[53:37] !== want.dest_y)
                    report_mismatch("dest_y", m_tdata[53:37], want.dest_y);
                if (m_tdata[69:54] !== want.text_total)
                    report_mismatch("text_total", m_tdata[69:54], want.text_total);
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ORIGIN_X;
        cfg_data  = 16'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 48'd0;
        s_tuser   = OP_LOAD;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_table_loads();
        test_layout_cases();
        test_measure_cases();
        test_saturation();
        test_random_texts();

        wait_idle();
        if (draws_due.size() != 0)
            report_mismatch("results still pending at end", draws_due.size(), 0);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gtl_pkg.sv
rtl/gtl_ram.sv
rtl/gtl_ctrl.sv
rtl/gtl_datapath.sv
rtl/glyph_text_layout.sv
verif/tb_glyph_text_layout.sv
